FILE: src/fal_pkg.sv
// shared types and constants for the frame alignment lcm core
`timescale 1ns / 1ps
`default_nettype none
package fal_pkg;

	localparam int unsigned ALU_W = 21;

	localparam logic [6:0] ALIGN_BYTES_MAX = 7'd64;
	localparam logic [6:0] FRAME_ALIGN_MAX = 7'd64;
	localparam logic [8:0] FRAME_BYTES_MAX = 9'd256;
	localparam logic [4:0] LOG2_K_MAX      = 5'd31;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] res;
		logic             cout;
		logic             zero;
	} alu_rsp_t;

	typedef struct packed {
		logic [8:0] frame_bytes;
		logic [6:0] frame_align;
		logic [6:0] align_bytes;
	} fal_arg_t;

	typedef struct packed {
		logic [4:0]  size_log2_ceil;
		logic [20:0] chunk_bytes;
		logic [12:0] align_frames;
	} fal_res_t;

	typedef struct packed {
		logic idle;
		logic res_valid;
	} fal_stat_t;

endpackage
`default_nettype wire

FILE: src/fal_alu.sv
// shared add / subtract unit with carry-out and zero flag
`timescale 1ns / 1ps
`default_nettype none
module fal_alu
	import fal_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [ALU_W:0] full;

	always_comb begin
		unique case (req.op)
			ALU_ADD: full = {1'b0, req.a} + {1'b0, req.b};
			ALU_SUB: full = {1'b0, req.a} - {1'b0, req.b};
			default: full = '0;
		endcase
		rsp.res  = full[ALU_W-1:0];
		// on subtract this is the borrow: a < b
		rsp.cout = full[ALU_W];
		rsp.zero = (full[ALU_W-1:0] == '0);
	end

endmodule
`default_nettype wire

FILE: src/fal_seq.sv
// sequencer: gcd, division, shift-add multiply and log2 search on the shared alu
`timescale 1ns / 1ps
`default_nettype none
module fal_seq
	import fal_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  fal_arg_t  arg,
	input  logic      res_take,
	output fal_stat_t stat,
	output fal_res_t  res
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GCD1,
		ST_DIV1,
		ST_GCD2,
		ST_DIV2,
		ST_MUL1,
		ST_MUL2,
		ST_LOG,
		ST_DONE
	} state_t;

	state_t      state_q;
	logic [6:0]  ba_q, fa_q, nfr_q;
	logic [8:0]  fb_q;
	logic [8:0]  x_q, y_q;
	logic [6:0]  rem_q, quo_q;
	logic [3:0]  cnt_q;
	logic [20:0] acc_q, mcand_q, pow_q;
	logic [8:0]  mplier_q;
	logic [4:0]  k_q;
	logic [12:0] frames_q;

	alu_req_t    req;
	alu_rsp_t    rsp;
	logic [6:0]  rsh;
	logic [6:0]  quo_nx, rem_nx;

	fal_alu u_alu (
		.req (req),
		.rsp (rsp)
	);

	// restoring division: bring down the next dividend bit
	assign rsh    = {rem_q[5:0], quo_q[6]};
	assign quo_nx = {quo_q[5:0], ~rsp.cout};
	assign rem_nx = rsp.cout ? rsh : rsp.res[6:0];

	always_comb begin
		req.op = ALU_ADD;
		req.a  = '0;
		req.b  = '0;
		unique case (state_q)
			ST_GCD1, ST_GCD2: begin
				req.op = ALU_SUB;
				req.a  = {12'd0, x_q};
				req.b  = {12'd0, y_q};
			end
			ST_DIV1, ST_DIV2: begin
				req.op = ALU_SUB;
				req.a  = {14'd0, rsh};
				req.b  = {14'd0, x_q[6:0]};
			end
			ST_MUL1, ST_MUL2: begin
				req.op = ALU_ADD;
				req.a  = acc_q;
				req.b  = mplier_q[0] ? mcand_q : '0;
			end
			ST_LOG: begin
				req.op = ALU_SUB;
				req.a  = pow_q;
				req.b  = acc_q;
			end
			default: begin
				req.op = ALU_ADD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ba_q     <= '0;
			fa_q     <= '0;
			fb_q     <= '0;
			nfr_q    <= '0;
			x_q      <= '0;
			y_q      <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			cnt_q    <= '0;
			acc_q    <= '0;
			mcand_q  <= '0;
			mplier_q <= '0;
			pow_q    <= '0;
			k_q      <= '0;
			frames_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						ba_q    <= arg.align_bytes;
						fa_q    <= arg.frame_align;
						fb_q    <= arg.frame_bytes;
						x_q     <= arg.frame_bytes;
						y_q     <= {2'd0, arg.align_bytes};
						state_q <= ST_GCD1;
					end
				end
				ST_GCD1, ST_GCD2: begin
					// subtractive euclid, keep x >= y
					if (rsp.cout) begin
						x_q <= y_q;
						y_q <= x_q;
					end else if (rsp.zero) begin
						rem_q   <= '0;
						quo_q   <= (state_q == ST_GCD1) ? ba_q : fa_q;
						cnt_q   <= '0;
						state_q <= (state_q == ST_GCD1) ? ST_DIV1 : ST_DIV2;
					end else begin
						x_q <= rsp.res[8:0];
					end
				end
				ST_DIV1, ST_DIV2: begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					if (cnt_q == 4'd6) begin
						cnt_q <= '0;
						if (state_q == ST_DIV1) begin
							nfr_q   <= quo_nx;
							x_q     <= {2'd0, quo_nx};
							y_q     <= {2'd0, fa_q};
							state_q <= ST_GCD2;
						end else begin
							acc_q    <= '0;
							mcand_q  <= {14'd0, nfr_q};
							mplier_q <= {2'd0, quo_nx};
							state_q  <= ST_MUL1;
						end
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				ST_MUL1, ST_MUL2: begin
					if (cnt_q == 4'd8) begin
						cnt_q <= '0;
						if (state_q == ST_MUL1) begin
							// lcm done, now scale by the frame size
							frames_q <= rsp.res[12:0];
							mcand_q  <= {8'd0, rsp.res[12:0]};
							mplier_q <= fb_q;
							acc_q    <= '0;
							state_q  <= ST_MUL2;
						end else begin
							acc_q   <= rsp.res;
							pow_q   <= 21'd1;
							k_q     <= '0;
							state_q <= ST_LOG;
						end
					end else begin
						acc_q    <= rsp.res;
						mcand_q  <= {mcand_q[19:0], 1'b0};
						mplier_q <= {1'b0, mplier_q[8:1]};
						cnt_q    <= cnt_q + 4'd1;
					end
				end
				ST_LOG: begin
					// borrow means pow < chunk
					if (rsp.cout && (k_q != LOG2_K_MAX)) begin
						pow_q <= {pow_q[19:0], 1'b0};
						k_q   <= k_q + 5'd1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign stat.idle          = (state_q == ST_IDLE);
	assign stat.res_valid     = (state_q == ST_DONE);
	assign res.align_frames   = frames_q;
	assign res.chunk_bytes    = acc_q;
	assign res.size_log2_ceil = k_q;

endmodule
`default_nettype wire

FILE: src/frame_alignment_lcm_core.sv
// top level: input clamp, sequencer and output register of the frame alignment lcm core
//
//  channel  | dir | tdata fields (lsb first)                                    | tuser
//  s_axis   | in  | align_bytes[6:0] frame_align[13:7] frame_bytes[22:14]       | -
//  m_axis   | out | align_frames[12:0] chunk_bytes[33:13] size_log2_ceil[38:34] | -
//
// one item at a time on the shared alu; an item holds the sequencer through both gcd loops,
// the two divisions, the two shift-add multiplies, the log2 search and the done state;
// s_tready is high only while the sequencer is idle
// a finished result sits in the output register so the next item can start while it waits
// arst_n clears the sequencer and the output valid; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module frame_alignment_lcm_core
	import fal_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // align_bytes, frame_align, frame_bytes, pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // align_frames, chunk_bytes, size_log2_ceil, pad
);

	fal_arg_t  arg;
	fal_res_t  res;
	fal_stat_t stat;
	fal_res_t  out_q;
	logic      m_tvalid_q;
	logic      start;
	logic      res_take;
	logic [6:0] ba_in, fa_in;
	logic [8:0] fb_in;

	assign ba_in = s_tdata[6:0];
	assign fa_in = s_tdata[13:7];
	assign fb_in = s_tdata[22:14];

	// zero reads as one, above range saturates
	always_comb begin
		arg.align_bytes = (ba_in == '0) ? 7'd1 :
		                  (ba_in > ALIGN_BYTES_MAX) ? ALIGN_BYTES_MAX : ba_in;
		arg.frame_align = (fa_in == '0) ? 7'd1 :
		                  (fa_in > FRAME_ALIGN_MAX) ? FRAME_ALIGN_MAX : fa_in;
		arg.frame_bytes = (fb_in == '0) ? 9'd1 :
		                  (fb_in > FRAME_BYTES_MAX) ? FRAME_BYTES_MAX : fb_in;
	end

	assign s_tready = stat.idle;
	assign start    = s_tvalid & stat.idle;
	assign res_take = stat.res_valid & (~m_tvalid_q | m_tready);

	fal_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.arg      (arg),
		.res_take (res_take),
		.stat     (stat),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			out_q      <= '0;
		end else begin
			if (res_take) begin
				m_tvalid_q <= 1'b1;
				out_q      <= res;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_q.size_log2_ceil, out_q.chunk_bytes, out_q.align_frames};

endmodule
`default_nettype wire
